// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the top-level RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg)

`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ----- rtl/imte_pkg.sv -----
`default_nettype none

package imte_pkg;

   localparam int PayloadDepth = 64;
   localparam int PayloadAw    = $clog2(PayloadDepth);
   localparam int FillW        = $clog2(PayloadDepth + 1);
   localparam int InstantSteps = 6;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NACK    = 2'd1;
   localparam logic [1:0] ST_TIMEOUT = 2'd2;
   localparam logic [1:0] ST_LOCKED  = 2'd3;

   localparam logic [1:0] MODE_TICK  = 2'd0;
   localparam logic [1:0] MODE_PUSH  = 2'd1;
   localparam logic [1:0] MODE_BEGIN = 2'd2;

   localparam logic [1:0] KIND_STREAM = 2'd0;
   localparam logic [1:0] KIND_REG_WR = 2'd1;
   localparam logic [1:0] KIND_REG_RD = 2'd2;

   localparam logic [1:0] REG_HALF    = 2'd0;
   localparam logic [1:0] REG_STRETCH = 2'd1;
   localparam logic [1:0] REG_TXN     = 2'd2;
   localparam logic [1:0] REG_PULSES  = 2'd3;

   typedef enum logic [4:0] {
      PH_IDLE      = 5'd0,
      PH_PREP_CHK  = 5'd1,
      PH_START     = 5'd2,
      PH_START_CHK = 5'd3,
      PH_START_B   = 5'd4,
      PH_START_C   = 5'd5,
      PH_NEXT      = 5'd6,
      PH_REC_PULSE = 5'd7,
      PH_REC_PCHK  = 5'd8,
      PH_REC_END   = 5'd9,
      PH_REC_E2    = 5'd10,
      PH_REC_E3    = 5'd11,
      PH_REC_E4    = 5'd12,
      PH_WB_BIT    = 5'd13,
      PH_WB_BCHK   = 5'd14,
      PH_WB_ACK    = 5'd15,
      PH_WB_ACHK   = 5'd16,
      PH_WB_AEND   = 5'd17,
      PH_RB_BIT    = 5'd18,
      PH_RB_BCHK   = 5'd19,
      PH_RB_ACK    = 5'd20,
      PH_RB_ACHK   = 5'd21,
      PH_RB_AEND   = 5'd22,
      PH_ST        = 5'd23,
      PH_ST_B      = 5'd24,
      PH_ST_C      = 5'd25,
      PH_ST_D      = 5'd26
   } phase_type;

   typedef enum logic [1:0] {
      W_NONE  = 2'd0,
      W_HIGH  = 2'd1,
      W_DELAY = 2'd2
   } wait_type;

   typedef enum logic [2:0] {
      SEG_START1  = 3'd0,
      SEG_ADDR    = 3'd1,
      SEG_REG     = 3'd2,
      SEG_RESTART = 3'd3,
      SEG_RADDR   = 3'd4,
      SEG_DATA    = 3'd5
   } seg_type;

   typedef struct packed {
      logic [7:0]  half_period_ticks;
      logic [15:0] stretch_limit_ticks;
      logic [17:0] transaction_limit_ticks;
      logic [3:0]  recovery_pulse_count;
   } cfg_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       sda_level;
      logic       scl_level;
      logic [1:0] transfer_kind;
      logic [6:0] device_address;
      logic [7:0] first_register;
      logic [6:0] transfer_length;
      logic [7:0] payload_byte;
   } req_type;

   typedef struct packed {
      logic       scl_pull_low;
      logic       sda_pull_low;
      logic       busy_res;
      logic       read_valid;
      logic [7:0] read_value;
      logic       read_final;
      logic       done_res;
      logic [1:0] status;
   } rsp_type;

   typedef struct packed {
      phase_type        phase;
      logic [3:0]       bit_counter;
      logic [6:0]       byte_counter;
      logic [7:0]       shift_byte;
      logic [FillW-1:0] payload_fill;
      logic [17:0]      elapsed_ticks;
      logic [15:0]      stretch_ticks;
      logic [7:0]       half_ticks;
      logic [3:0]       pulse_counter;
      logic [1:0]       held_status;
      logic             start_sent;
      logic             scl_drv;
      logic             sda_drv;
      logic [1:0]       kind;
      logic [6:0]       dev_addr;
      logic [7:0]       first_register;
      logic [6:0]       length;
      wait_type         wait_mode;
      seg_type          segment;
      logic             hold_after;
      logic             timed_out;
      logic             acked;
      logic             rec_in_start;
      logic             rd_valid;
      logic [7:0]       rd_value;
      logic             rd_final;
      logic             done;
   } eng_type;

   function automatic logic expired(eng_type s, cfg_type c);
      return s.elapsed_ticks >= c.transaction_limit_ticks;
   endfunction

   function automatic eng_type go_delay(eng_type s, phase_type nxt, cfg_type c);
      eng_type r;
      r = s;
      r.half_ticks = (c.half_period_ticks == 8'd0) ? 8'd1 : c.half_period_ticks;
      r.wait_mode  = W_DELAY;
      r.phase      = nxt;
      return r;
   endfunction

   function automatic eng_type go_lower(eng_type s, phase_type nxt, cfg_type c);
      eng_type r;
      r = s;
      r.scl_drv = 1'b1;
      return go_delay(r, nxt, c);
   endfunction

   function automatic eng_type go_raise(eng_type s, phase_type nxt, cfg_type c);
      eng_type r;
      r = s;
      r.phase     = nxt;
      r.timed_out = 1'b0;
      // deadline already gone: fail without letting SCL go
      if (expired(r, c)) begin
         r.timed_out = 1'b1;
      end else begin
         r.scl_drv       = 1'b0;
         r.stretch_ticks = 16'd0;
         r.hold_after    = 1'b1;
         r.wait_mode     = W_HIGH;
      end
      return r;
   endfunction

   function automatic eng_type go_waithi(eng_type s, phase_type nxt);
      eng_type r;
      r = s;
      r.scl_drv       = 1'b0;
      r.sda_drv       = 1'b0;
      r.stretch_ticks = 16'd0;
      r.hold_after    = 1'b0;
      r.timed_out     = 1'b0;
      r.wait_mode     = W_HIGH;
      r.phase         = nxt;
      return r;
   endfunction

   function automatic eng_type finish(eng_type s, logic [1:0] end_code);
      eng_type r;
      r = s;
      if (r.held_status == ST_OK) begin
         r.held_status = end_code;
      end
      r.scl_drv   = 1'b0;
      r.sda_drv   = 1'b0;
      r.wait_mode = W_NONE;
      r.phase     = PH_IDLE;
      r.done      = 1'b1;
      return r;
   endfunction

   function automatic eng_type fail(eng_type s, logic [1:0] err);
      eng_type r;
      r = s;
      r.held_status = err;
      if (r.start_sent) begin
         r.phase = PH_ST;
      end else begin
         r = finish(r, ST_OK);
      end
      return r;
   endfunction

   function automatic eng_type write_begin(eng_type s, logic [7:0] v);
      eng_type r;
      r = s;
      r.shift_byte  = v;
      r.bit_counter = 4'd0;
      r.phase       = PH_WB_BIT;
      return r;
   endfunction

   function automatic eng_type rec_enter(eng_type s, logic in_start);
      eng_type r;
      r = s;
      r.rec_in_start  = in_start;
      r.scl_drv       = 1'b0;
      r.sda_drv       = 1'b0;
      r.pulse_counter = 4'd0;
      r.phase         = PH_REC_PULSE;
      return r;
   endfunction

   function automatic eng_type data_next(eng_type s, logic [7:0] pd);
      eng_type r;
      r = s;
      if (r.byte_counter >= r.length) begin
         r.phase = PH_ST;
      end else if (r.kind == KIND_REG_RD) begin
         r.sda_drv     = 1'b0;
         r.bit_counter = 4'd0;
         r.shift_byte  = 8'd0;
         r.phase       = PH_RB_BIT;
      end else begin
         // pd is the prefetched payload entry at byte_counter
         r.byte_counter = r.byte_counter + 7'd1;
         r = write_begin(r, pd);
      end
      return r;
   endfunction

   function automatic eng_type advance(eng_type s, logic [7:0] pd);
      eng_type r;
      r = s;
      unique case (r.segment)
         SEG_START1: begin
            r.segment = SEG_ADDR;
            r = write_begin(r, {r.dev_addr, 1'b0});
         end
         SEG_ADDR: begin
            if (r.kind == KIND_STREAM) begin
               r.segment = SEG_DATA;
               r = data_next(r, pd);
            end else begin
               r.segment = SEG_REG;
               r = write_begin(r, r.first_register);
            end
         end
         SEG_REG: begin
            if (r.kind == KIND_REG_WR) begin
               r.segment = SEG_DATA;
               r = data_next(r, pd);
            end else begin
               r.segment = SEG_RESTART;
               r.phase   = PH_START;
            end
         end
         SEG_RESTART: begin
            r.segment = SEG_RADDR;
            r = write_begin(r, {r.dev_addr, 1'b1});
         end
         SEG_RADDR: begin
            r.segment = SEG_DATA;
            r = data_next(r, pd);
         end
         default: begin
            r = data_next(r, pd);
         end
      endcase
      return r;
   endfunction

   function automatic eng_type run_instant(eng_type s, logic sda, logic scl, cfg_type c,
                                           logic [7:0] pd);
      eng_type    r;
      logic [7:0] nb;
      r  = s;
      nb = {1'b0, r.byte_counter} + 8'd1;
      unique case (r.phase)
         PH_PREP_CHK: begin
            if (r.timed_out)  r = fail(r, ST_TIMEOUT);
            else if (sda)     r.phase = PH_START;
            else              r = rec_enter(r, 1'b0);
         end
         PH_START: r = go_waithi(r, PH_START_CHK);
         PH_START_CHK: begin
            if (r.timed_out)  r = fail(r, ST_TIMEOUT);
            else if (!sda)    r = rec_enter(r, 1'b1);
            else              r = go_delay(r, PH_START_B, c);
         end
         PH_START_B: begin
            r.sda_drv = 1'b1;
            r = go_delay(r, PH_START_C, c);
         end
         PH_START_C: begin
            r.scl_drv    = 1'b1;
            r.start_sent = 1'b1;
            r = go_delay(r, PH_NEXT, c);
         end
         PH_NEXT: r = advance(r, pd);
         PH_REC_PULSE: begin
            if (r.pulse_counter >= c.recovery_pulse_count) r.phase = PH_REC_END;
            else r = go_raise(r, PH_REC_PCHK, c);
         end
         PH_REC_PCHK: begin
            if (r.timed_out) begin
               r = fail(r, ST_TIMEOUT);
            end else if (sda) begin
               r.phase = PH_REC_END;
            end else begin
               r.pulse_counter = r.pulse_counter + 4'd1;
               r = go_lower(r, PH_REC_PULSE, c);
            end
         end
         PH_REC_END: begin
            r.sda_drv = 1'b1;
            r = go_delay(r, PH_REC_E2, c);
         end
         PH_REC_E2: r = go_raise(r, PH_REC_E3, c);
         PH_REC_E3: begin
            if (r.timed_out) begin
               r.scl_drv = 1'b0;
               r.sda_drv = 1'b0;
               r = fail(r, ST_TIMEOUT);
            end else begin
               r.sda_drv = 1'b0;
               r = go_delay(r, PH_REC_E4, c);
            end
         end
         PH_REC_E4: begin
            if (!sda || !scl)         r = fail(r, ST_LOCKED);
            else if (r.rec_in_start)  r = go_delay(r, PH_START_B, c);
            else                      r.phase = PH_START;
         end
         PH_WB_BIT: begin
            if (r.bit_counter >= 4'd8) begin
               r.phase = PH_WB_ACK;
            end else begin
               r.sda_drv = ~r.shift_byte[7];
               r = go_raise(r, PH_WB_BCHK, c);
            end
         end
         PH_WB_BCHK: begin
            if (r.timed_out) begin
               r.sda_drv = 1'b0;
               r = fail(r, ST_TIMEOUT);
            end else begin
               r.shift_byte  = {r.shift_byte[6:0], 1'b0};
               r.bit_counter = r.bit_counter + 4'd1;
               r = go_lower(r, PH_WB_BIT, c);
            end
         end
         PH_WB_ACK: begin
            r.sda_drv = 1'b0;
            r = go_raise(r, PH_WB_ACHK, c);
         end
         PH_WB_ACHK: begin
            if (r.timed_out) begin
               r = fail(r, ST_TIMEOUT);
            end else begin
               r.acked = ~sda;
               r = go_lower(r, PH_WB_AEND, c);
            end
         end
         PH_WB_AEND: begin
            if (!r.acked) r = fail(r, ST_NACK);
            else          r = advance(r, pd);
         end
         PH_RB_BIT: begin
            if (r.bit_counter >= 4'd8) r.phase = PH_RB_ACK;
            else r = go_raise(r, PH_RB_BCHK, c);
         end
         PH_RB_BCHK: begin
            if (r.timed_out) begin
               r = fail(r, ST_TIMEOUT);
            end else begin
               r.shift_byte  = {r.shift_byte[6:0], sda};
               r.bit_counter = r.bit_counter + 4'd1;
               r = go_lower(r, PH_RB_BIT, c);
            end
         end
         PH_RB_ACK: begin
            // ACK all bytes but the last
            r.sda_drv = (nb < {1'b0, r.length});
            r = go_raise(r, PH_RB_ACHK, c);
         end
         PH_RB_ACHK: begin
            if (r.timed_out) begin
               r.sda_drv = 1'b0;
               r = fail(r, ST_TIMEOUT);
            end else begin
               r = go_lower(r, PH_RB_AEND, c);
            end
         end
         PH_RB_AEND: begin
            r.sda_drv      = 1'b0;
            r.rd_valid     = 1'b1;
            r.rd_value     = r.shift_byte;
            r.rd_final     = (nb >= {1'b0, r.length});
            r.byte_counter = nb[6:0];
            r = advance(r, pd);
         end
         PH_ST: begin
            r.sda_drv = 1'b1;
            r = go_delay(r, PH_ST_B, c);
         end
         PH_ST_B: r = go_raise(r, PH_ST_C, c);
         PH_ST_C: begin
            r.sda_drv = 1'b0;
            if (r.timed_out) r = finish(r, ST_TIMEOUT);
            else             r = go_delay(r, PH_ST_D, c);
         end
         PH_ST_D: r = finish(r, sda ? ST_OK : ST_LOCKED);
         default: begin
            r.phase   = PH_IDLE;
            r.scl_drv = 1'b0;
            r.sda_drv = 1'b0;
         end
      endcase
      return r;
   endfunction

   function automatic eng_type tick(eng_type s, logic sda, logic scl, cfg_type c,
                                    logic [7:0] pd);
      eng_type r;
      logic    run;
      r   = s;
      run = 1'b1;
      if (r.elapsed_ticks != 18'h3FFFF) begin
         r.elapsed_ticks = r.elapsed_ticks + 18'd1;
      end
      unique case (r.wait_mode)
         W_HIGH: begin
            if (scl) begin
               if (r.hold_after) begin
                  r   = go_delay(r, r.phase, c);
                  run = 1'b0;
               end else begin
                  r.wait_mode = W_NONE;
               end
            end else if (expired(r, c) || r.stretch_ticks >= c.stretch_limit_ticks) begin
               r.wait_mode = W_NONE;
               r.timed_out = 1'b1;
            end else begin
               r.stretch_ticks = r.stretch_ticks + 16'd1;
               run = 1'b0;
            end
         end
         W_DELAY: begin
            r.half_ticks = r.half_ticks - 8'd1;
            if (r.half_ticks != 8'd0) run = 1'b0;
            else r.wait_mode = W_NONE;
         end
         default: ;
      endcase
      // phases that need no wait chain within the same tick
      for (int i = 0; i < InstantSteps; i++) begin
         if (run && r.phase != PH_IDLE && r.wait_mode == W_NONE) begin
            r = run_instant(r, sda, scl, c, pd);
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/imte_csr.sv -----
`default_nettype none

module imte_csr import imte_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready,
   output cfg_type          cfg
);

   cfg_type    cfg_ff, cfg_in;
   logic       wr_en;
   logic [1:0] idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign idx        = csr_paddr[3:2];
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_HALF:    cfg_in.half_period_ticks       = csr_pwdata[7:0];
            REG_STRETCH: cfg_in.stretch_limit_ticks     = csr_pwdata[15:0];
            REG_TXN:     cfg_in.transaction_limit_ticks = csr_pwdata[17:0];
            REG_PULSES:  cfg_in.recovery_pulse_count    = csr_pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_HALF:    csr_prdata = {24'd0, cfg_ff.half_period_ticks};
         REG_STRETCH: csr_prdata = {16'd0, cfg_ff.stretch_limit_ticks};
         REG_TXN:     csr_prdata = {14'd0, cfg_ff.transaction_limit_ticks};
         REG_PULSES:  csr_prdata = {28'd0, cfg_ff.recovery_pulse_count};
         default:     csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_period_ticks       <= 8'd5;
         cfg_ff.stretch_limit_ticks     <= 16'd300;
         cfg_ff.transaction_limit_ticks <= 18'd150000;
         cfg_ff.recovery_pulse_count    <= 4'd9;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/imte_sequencer.sv -----
`default_nettype none

module imte_sequencer import imte_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic step_en,
   input  req_type   req,
   input  cfg_type   cfg,
   output rsp_type   rsp
);

   eng_type             st_ff, st_in;
   logic [7:0]          payload_mem [PayloadDepth];
   logic [7:0]          pd_ff;
   logic                mem_we;
   logic                busy;
   logic                bad;
   logic [FillW-1:0]    fill_old;

   assign busy = (st_ff.phase != PH_IDLE);

   always_comb begin
      st_in          = st_ff;
      st_in.rd_valid = 1'b0;
      st_in.rd_value = 8'd0;
      st_in.rd_final = 1'b0;
      st_in.done     = 1'b0;
      mem_we         = 1'b0;
      fill_old       = st_ff.payload_fill;
      bad            = 1'b0;
      unique case (req.mode)
         MODE_TICK: begin
            if (busy) st_in = tick(st_in, req.sda_level, req.scl_level, cfg, pd_ff);
         end
         MODE_PUSH: begin
            if (!busy && st_ff.payload_fill < FillW'(PayloadDepth)) begin
               mem_we             = 1'b1;
               st_in.payload_fill = st_ff.payload_fill + FillW'(1);
            end
         end
         MODE_BEGIN: begin
            if (!busy) begin
               st_in.payload_fill = '0;
               bad = (req.transfer_kind == 2'd3) ||
                     ({1'b0, req.transfer_length} > 8'(PayloadDepth)) ||
                     (req.transfer_kind == KIND_REG_RD && req.transfer_length == 7'd0) ||
                     (req.transfer_kind != KIND_REG_RD &&
                      9'(req.transfer_length) > 9'(fill_old));
               if (bad) begin
                  st_in.done        = 1'b1;
                  st_in.held_status = ST_LOCKED;
               end else begin
                  st_in.kind           = req.transfer_kind;
                  st_in.dev_addr       = req.device_address;
                  st_in.first_register = req.first_register;
                  st_in.length         = req.transfer_length;
                  st_in.held_status    = ST_OK;
                  st_in.start_sent     = 1'b0;
                  st_in.elapsed_ticks  = 18'd0;
                  st_in.byte_counter   = 7'd0;
                  st_in.bit_counter    = 4'd0;
                  st_in.segment        = SEG_START1;
                  st_in = go_waithi(st_in, PH_PREP_CHK);
               end
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp.scl_pull_low = st_in.scl_drv;
      rsp.sda_pull_low = st_in.sda_drv;
      rsp.busy_res     = (st_in.phase != PH_IDLE);
      rsp.read_valid   = st_in.rd_valid;
      rsp.read_value   = st_in.rd_valid ? st_in.rd_value : 8'd0;
      rsp.read_final   = st_in.rd_valid & st_in.rd_final;
      rsp.done_res     = st_in.done;
      rsp.status       = st_in.done ? st_in.held_status : ST_OK;
   end

   // all-zero state is idle, no wait, first segment
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '0;
      end else if (step_en) begin
         st_ff <= st_in;
      end
   end

   // write side takes pushes; the read side keeps the entry at byte_counter ready
   always_ff @(posedge clock) begin
      if (step_en && mem_we) begin
         payload_mem[st_ff.payload_fill[PayloadAw-1:0]] <= req.payload_byte;
      end
      pd_ff <= payload_mem[st_ff.byte_counter[PayloadAw-1:0]];
   end

endmodule

`default_nettype wire

// ----- rtl/i2c_master_transaction_engine.sv -----
// channel   dir  handshake          payload
// req       in   tvalid/tready      tuser=mode, tdata=line samples and request fields
// rsp       out  tvalid/tready      tdata=drives, flags, read byte, status; tlast=read_final
// csr       in   APB psel/penable   four registers at byte addresses 0, 4, 8, 12
//
// One transaction per clock sustained while the rsp side does not stall; each result
// passes through the input register, then the result register.
// The sequencer state advances only when a transaction moves from the input
// register into the result register, so a stalled rsp side holds everything.
// Reset is synchronous and returns the engine to idle with default registers.
`default_nettype none
`include "assert_macros.svh"

module i2c_master_transaction_engine import imte_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [0] sda_level, [1] scl_level, [3:2] transfer_kind, [10:4] device_address,
   // [18:11] first_register, [25:19] transfer_length, [33:26] payload_byte
   input  wire logic [39:0] req_tdata,
   // [1:0] mode
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [0] scl_pull_low, [1] sda_pull_low, [2] busy_res, [3] read_valid,
   // [11:4] read_value, [12] done_res, [14:13] status
   output logic [15:0]      rsp_tdata,
   output logic             rsp_tlast,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff, in_data_in;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;
   logic    move;
   cfg_type cfg;
   rsp_type step_rsp;

   assign move       = in_valid_ff & (~out_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | move;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in                = 1'b1;
         in_data_in.mode            = req_tuser;
         in_data_in.sda_level       = req_tdata[0];
         in_data_in.scl_level       = req_tdata[1];
         in_data_in.transfer_kind   = req_tdata[3:2];
         in_data_in.device_address  = req_tdata[10:4];
         in_data_in.first_register  = req_tdata[18:11];
         in_data_in.transfer_length = req_tdata[25:19];
         in_data_in.payload_byte    = req_tdata[33:26];
      end else if (move) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (move) begin
         out_valid_in = 1'b1;
         out_data_in  = step_rsp;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   imte_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   imte_sequencer u_seq (
      .clock   (clock),
      .reset   (reset),
      .step_en (move),
      .req     (in_data_ff),
      .cfg     (cfg),
      .rsp     (step_rsp)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_data_ff.status, out_data_ff.done_res,
                        out_data_ff.read_value, out_data_ff.read_valid,
                        out_data_ff.busy_res, out_data_ff.sda_pull_low,
                        out_data_ff.scl_pull_low};
   assign rsp_tlast  = out_data_ff.read_final;

   `ASSERT_ALWAYS(a_done_idle, clock, reset, !(rsp_tvalid && out_data_ff.done_res && out_data_ff.busy_res), "done reported while busy")
   `ASSERT_ALWAYS(a_done_released, clock, reset, !(rsp_tvalid && out_data_ff.done_res && (out_data_ff.scl_pull_low || out_data_ff.sda_pull_low)), "lines driven at done")
   `ASSERT_ALWAYS(a_last_valid, clock, reset, !(rsp_tvalid && rsp_tlast && !out_data_ff.read_valid), "read_final without read byte")
   `ASSERT_NEXT(a_move_result, clock, reset, move, rsp_tvalid, "moved transaction produced no result")

endmodule

`default_nettype wire

// ----- verif/i2c_engine_checker.sv -----
`timescale 1ns / 100ps

module i2c_engine_checker import imte_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   input  logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          errors,
   output int          outstanding
);

   typedef struct {
      logic       scl_low;
      logic       sda_low;
      logic       busy;
      logic       rd_valid;
      logic [7:0] rd_value;
      logic       rd_final;
      logic       done;
      logic [1:0] status;
   } line_result;

   line_result expected_lines[$];

   logic [7:0]  half_cfg;
   logic [15:0] stretch_cfg;
   logic [17:0] deadline_cfg;
   logic [3:0]  pulse_cfg;

   phase_type   ph;
   wait_type    wmode;
   seg_type     seg;
   logic [3:0]  bitn;
   logic [6:0]  bytec;
   logic [7:0]  shreg;
   logic [6:0]  fill;
   logic [17:0] elapsed;
   logic [15:0] stretch_cnt;
   logic [7:0]  half_cnt;
   logic [3:0]  pulse_cnt;
   logic [1:0]  held;
   logic        started, scl_d, sda_d;
   logic [1:0]  kind;
   logic [6:0]  addr;
   logic [7:0]  regb;
   logic [6:0]  len;
   logic        hold_after, timed_out, acked, rec_start;
   logic        o_valid, o_final, o_done;
   logic [7:0]  o_value;
   logic [7:0]  payload [PayloadDepth];

   initial errors = 0;

   function automatic void reset_engine();
      half_cfg = 8'd5;
      stretch_cfg = 16'd300;
      deadline_cfg = 18'd150000;
      pulse_cfg = 4'd9;
      ph = PH_IDLE;
      wmode = W_NONE;
      seg = SEG_START1;
      bitn = '0; bytec = '0; shreg = '0; fill = '0;
      elapsed = '0; stretch_cnt = '0; half_cnt = '0; pulse_cnt = '0;
      held = ST_OK;
      started = 0; scl_d = 0; sda_d = 0;
      kind = '0; addr = '0; regb = '0; len = '0;
      hold_after = 0; timed_out = 0; acked = 0; rec_start = 0;
      for (int i = 0; i < PayloadDepth; i++) payload[i] = 8'd0;
   endfunction

   function automatic void delay_to(phase_type n);
      half_cnt = (half_cfg == 8'd0) ? 8'd1 : half_cfg;
      wmode = W_DELAY;
      ph = n;
   endfunction

   function automatic void lower_to(phase_type n);
      scl_d = 1;
      delay_to(n);
   endfunction

   function automatic void raise_to(phase_type n);
      ph = n;
      timed_out = 0;
      if (elapsed >= deadline_cfg) begin
         timed_out = 1;
         return;
      end
      scl_d = 0;
      stretch_cnt = '0;
      hold_after = 1;
      wmode = W_HIGH;
   endfunction

   function automatic void wait_high(phase_type n);
      scl_d = 0;
      sda_d = 0;
      stretch_cnt = '0;
      hold_after = 0;
      timed_out = 0;
      wmode = W_HIGH;
      ph = n;
   endfunction

   function automatic void close_out(logic [1:0] stop_st);
      if (held == ST_OK) held = stop_st;
      scl_d = 0;
      sda_d = 0;
      wmode = W_NONE;
      ph = PH_IDLE;
      o_done = 1;
   endfunction

   // once a START went out, every error still ends with a STOP
   function automatic void abort(logic [1:0] err);
      held = err;
      if (started) ph = PH_ST;
      else close_out(ST_OK);
   endfunction

   function automatic void send_byte(logic [7:0] v);
      shreg = v;
      bitn = '0;
      ph = PH_WB_BIT;
   endfunction

   function automatic void recover(logic in_start);
      rec_start = in_start;
      scl_d = 0;
      sda_d = 0;
      pulse_cnt = '0;
      ph = PH_REC_PULSE;
   endfunction

   function automatic void next_data();
      logic [7:0] v;
      if (bytec >= len) begin
         ph = PH_ST;
      end else if (kind == KIND_REG_RD) begin
         sda_d = 0;
         bitn = '0;
         shreg = '0;
         ph = PH_RB_BIT;
      end else begin
         v = payload[bytec[5:0]];
         bytec = bytec + 7'd1;
         send_byte(v);
      end
   endfunction

   function automatic void next_segment();
      case (seg)
         SEG_START1: begin
            seg = SEG_ADDR;
            send_byte({addr, 1'b0});
         end
         SEG_ADDR: begin
            if (kind == KIND_STREAM) begin
               seg = SEG_DATA;
               next_data();
            end else begin
               seg = SEG_REG;
               send_byte(regb);
            end
         end
         SEG_REG: begin
            if (kind == KIND_REG_WR) begin
               seg = SEG_DATA;
               next_data();
            end else begin
               seg = SEG_RESTART;
               ph = PH_START;
            end
         end
         SEG_RESTART: begin
            seg = SEG_RADDR;
            send_byte({addr, 1'b1});
         end
         SEG_RADDR: begin
            seg = SEG_DATA;
            next_data();
         end
         default: next_data();
      endcase
   endfunction

   function automatic void step_phase(logic sda, logic scl);
      case (ph)
         PH_PREP_CHK: begin
            if (timed_out) abort(ST_TIMEOUT);
            else if (sda) ph = PH_START;
            else recover(1'b0);
         end
         PH_START: wait_high(PH_START_CHK);
         PH_START_CHK: begin
            if (timed_out) abort(ST_TIMEOUT);
            else if (!sda) recover(1'b1);
            else delay_to(PH_START_B);
         end
         PH_START_B: begin
            sda_d = 1;
            delay_to(PH_START_C);
         end
         PH_START_C: begin
            scl_d = 1;
            started = 1;
            delay_to(PH_NEXT);
         end
         PH_NEXT: next_segment();
         PH_REC_PULSE: begin
            if (pulse_cnt >= pulse_cfg) ph = PH_REC_END;
            else raise_to(PH_REC_PCHK);
         end
         PH_REC_PCHK: begin
            if (timed_out) abort(ST_TIMEOUT);
            else if (sda) ph = PH_REC_END;
            else begin
               pulse_cnt = pulse_cnt + 4'd1;
               lower_to(PH_REC_PULSE);
            end
         end
         PH_REC_END: begin
            sda_d = 1;
            delay_to(PH_REC_E2);
         end
         PH_REC_E2: raise_to(PH_REC_E3);
         PH_REC_E3: begin
            if (timed_out) begin
               scl_d = 0;
               sda_d = 0;
               abort(ST_TIMEOUT);
            end else begin
               sda_d = 0;
               delay_to(PH_REC_E4);
            end
         end
         PH_REC_E4: begin
            if (!sda || !scl) abort(ST_LOCKED);
            else if (rec_start) delay_to(PH_START_B);
            else ph = PH_START;
         end
         PH_WB_BIT: begin
            if (bitn >= 4'd8) ph = PH_WB_ACK;
            else begin
               sda_d = ~shreg[7];
               raise_to(PH_WB_BCHK);
            end
         end
         PH_WB_BCHK: begin
            if (timed_out) begin
               sda_d = 0;
               abort(ST_TIMEOUT);
            end else begin
               shreg = {shreg[6:0], 1'b0};
               bitn = bitn + 4'd1;
               lower_to(PH_WB_BIT);
            end
         end
         PH_WB_ACK: begin
            sda_d = 0;
            raise_to(PH_WB_ACHK);
         end
         PH_WB_ACHK: begin
            if (timed_out) abort(ST_TIMEOUT);
            else begin
               acked = !sda;
               lower_to(PH_WB_AEND);
            end
         end
         PH_WB_AEND: begin
            if (!acked) abort(ST_NACK);
            else next_segment();
         end
         PH_RB_BIT: begin
            if (bitn >= 4'd8) ph = PH_RB_ACK;
            else raise_to(PH_RB_BCHK);
         end
         PH_RB_BCHK: begin
            if (timed_out) abort(ST_TIMEOUT);
            else begin
               shreg = {shreg[6:0], sda};
               bitn = bitn + 4'd1;
               lower_to(PH_RB_BIT);
            end
         end
         PH_RB_ACK: begin
            // master ACKs every byte except the last one
            sda_d = (int'(bytec) + 1 < int'(len));
            raise_to(PH_RB_ACHK);
         end
         PH_RB_ACHK: begin
            if (timed_out) begin
               sda_d = 0;
               abort(ST_TIMEOUT);
            end else lower_to(PH_RB_AEND);
         end
         PH_RB_AEND: begin
            sda_d = 0;
            o_valid = 1;
            o_value = shreg;
            o_final = (int'(bytec) + 1 >= int'(len));
            bytec = bytec + 7'd1;
            next_segment();
         end
         PH_ST: begin
            sda_d = 1;
            delay_to(PH_ST_B);
         end
         PH_ST_B: raise_to(PH_ST_C);
         PH_ST_C: begin
            sda_d = 0;
            if (timed_out) close_out(ST_TIMEOUT);
            else delay_to(PH_ST_D);
         end
         PH_ST_D: close_out(sda ? ST_OK : ST_LOCKED);
         default: begin
            ph = PH_IDLE;
            scl_d = 0;
            sda_d = 0;
         end
      endcase
   endfunction

   function automatic void bus_tick(logic sda, logic scl);
      if (elapsed != 18'h3FFFF) elapsed = elapsed + 18'd1;
      if (wmode == W_HIGH) begin
         if (scl) begin
            // SCL seen high after a raise: hold it for one half period
            if (hold_after) begin
               delay_to(ph);
               return;
            end
            wmode = W_NONE;
         end else if (elapsed >= deadline_cfg || stretch_cnt >= stretch_cfg) begin
            wmode = W_NONE;
            timed_out = 1;
         end else begin
            stretch_cnt = stretch_cnt + 16'd1;
            return;
         end
      end else if (wmode == W_DELAY) begin
         half_cnt = half_cnt - 8'd1;
         if (half_cnt != 8'd0) return;
         wmode = W_NONE;
      end
      while (ph != PH_IDLE && wmode == W_NONE) step_phase(sda, scl);
   endfunction

   function automatic void start_transfer(logic [39:0] td);
      logic [1:0] k;
      logic [6:0] l, f;
      k = td[3:2];
      l = td[25:19];
      f = fill;
      fill = '0;
      if (k > KIND_REG_RD || l > PayloadDepth || (k == KIND_REG_RD && l == 0) ||
          (k != KIND_REG_RD && l > f)) begin
         o_done = 1;
         held = ST_LOCKED;
         return;
      end
      kind = k;
      addr = td[10:4];
      regb = td[18:11];
      len = l;
      held = ST_OK;
      started = 0;
      elapsed = '0;
      bytec = '0;
      bitn = '0;
      seg = SEG_START1;
      wait_high(PH_PREP_CHK);
   endfunction

   function automatic line_result engine_step(logic [1:0] mode, logic [39:0] td);
      line_result r;
      logic busy;
      busy = (ph != PH_IDLE);
      o_valid = 0;
      o_final = 0;
      o_done = 0;
      o_value = '0;
      case (mode)
         MODE_TICK: if (busy) bus_tick(td[0], td[1]);
         MODE_PUSH: begin
            if (!busy && fill < PayloadDepth) begin
               payload[fill[5:0]] = td[33:26];
               fill = fill + 7'd1;
            end
         end
         MODE_BEGIN: if (!busy) start_transfer(td);
         default: ;
      endcase
      r.scl_low = scl_d;
      r.sda_low = sda_d;
      r.busy = (ph != PH_IDLE);
      r.rd_valid = o_valid;
      r.rd_value = o_valid ? o_value : 8'd0;
      r.rd_final = o_valid && o_final;
      r.done = o_done;
      r.status = o_done ? held : ST_OK;
      return r;
   endfunction

   function automatic void check_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
         $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      line_result e;
      if (reset) begin
         reset_engine();
         expected_lines.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_lines.size() == 0) begin
               $error("response transaction with no prediction pending");
               errors++;
            end else begin
               e = expected_lines.pop_front();
               check_field("scl_pull_low", e.scl_low, rsp_tdata[0]);
               check_field("sda_pull_low", e.sda_low, rsp_tdata[1]);
               check_field("busy_res", e.busy, rsp_tdata[2]);
               check_field("read_valid", e.rd_valid, rsp_tdata[3]);
               check_field("read_value", e.rd_value, rsp_tdata[11:4]);
               check_field("read_final", e.rd_final, rsp_tlast);
               check_field("done_res", e.done, rsp_tdata[12]);
               check_field("status", e.status, rsp_tdata[14:13]);
            end
         end
         if (req_tvalid && req_tready)
            expected_lines.push_back(engine_step(req_tuser, req_tdata));
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               REG_HALF:    half_cfg = csr_pwdata[7:0];
               REG_STRETCH: stretch_cfg = csr_pwdata[15:0];
               REG_TXN:     deadline_cfg = csr_pwdata[17:0];
               default:     pulse_cfg = csr_pwdata[3:0];
            endcase
         end
      end
      outstanding <= expected_lines.size();
   end

endmodule

// ----- verif/tb_i2c_master_transaction_engine.sv -----
`timescale 1ns / 100ps

module tb_i2c_master_transaction_engine import imte_pkg::*;;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam logic [1:0] KIND_BAD    = 2'd3;
   localparam int CycleLimit = 3000000;
   localparam int TickCap    = 40000;

   logic        clock, reset;
   logic        req_tvalid, req_tready;
   logic [39:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid, rsp_tready;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_psel, csr_penable, csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   logic        csr_pready;
   int          errors, outstanding;

   int   req_cnt, rsp_cnt, transfers, configs, cycles;
   logic last_scl_d, last_sda_d, last_done;
   bit   zero_gaps, hold_rsp;

   // simple target model following the master's drives
   int   slot, stretch_left, stuck_left, ack_pct, stretch_pct, stretch_max;
   bit   slave_bit;
   logic prev_scl_d, prev_sda_d;

   i2c_master_transaction_engine DUT (.*);
   i2c_engine_checker checker_i (.*);

   initial clock = 0;
   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      int gap;
      rsp_tready = 0;
      wait (reset == 0);
      forever begin
         gap = zero_gaps ? 0 : $urandom_range(0, 6);
         if (hold_rsp) begin
            gap = 300;
            hold_rsp = 0;
         end
         if (gap > 0) begin
            rsp_tready <= 0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1;
         do @(posedge clock); while (!rsp_tvalid);
         last_scl_d <= rsp_tdata[0];
         last_sda_d <= rsp_tdata[1];
         last_done  <= rsp_tdata[12];
         rsp_cnt    <= rsp_cnt + 1;
      end
   end

   task automatic send_item(input logic [1:0] mode, input logic sda, input logic scl,
                            input logic [1:0] kind, input logic [6:0] addr,
                            input logic [7:0] regb, input logic [6:0] len,
                            input logic [7:0] pb, input bit lockstep);
      int gap;
      gap = zero_gaps ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tuser  <= mode;
      req_tdata  <= {6'd0, pb, len, regb, addr, kind, scl, sda};
      req_tvalid <= 1;
      do @(posedge clock); while (!req_tready);
      req_cnt++;
      if (lockstep) begin
         req_tvalid <= 0;
         do @(posedge clock); while (rsp_cnt != req_cnt);
      end
   endtask

   task automatic drain();
      do @(posedge clock); while (outstanding != 0 || rsp_cnt != req_cnt);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] v);
      csr_psel    <= 1;
      csr_penable <= 0;
      csr_pwrite  <= 1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= v;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel    <= 0;
      csr_penable <= 0;
      csr_pwrite  <= 0;
      @(posedge clock);
   endtask

   task automatic apply_config(input int h, input int s, input int t, input int p);
      drain();
      repeat (4) @(posedge clock);
      csr_write(REG_HALF, h);
      csr_write(REG_STRETCH, s);
      csr_write(REG_TXN, t);
      csr_write(REG_PULSES, p);
      configs++;
   endtask

   task automatic line_tick();
      logic md_scl, md_sda, s_scl, s_sda;
      md_scl = last_scl_d;
      md_sda = last_sda_d;
      if (!md_scl && prev_scl_d && $urandom_range(0, 99) < stretch_pct)
         stretch_left = $urandom_range(1, stretch_max);
      // START or STOP seen on the drives
      if (md_sda && !prev_sda_d && !md_scl && !prev_scl_d) slot = 0;
      else if (!md_sda && prev_sda_d && !md_scl) slot = -1;
      if (md_scl && !prev_scl_d && slot >= 0) begin
         slot = (slot == 9) ? 1 : slot + 1;
         if (slot == 9) slave_bit = ($urandom_range(0, 99) < ack_pct);
         else slave_bit = $urandom_range(0, 1);
      end
      s_scl = !md_scl && stretch_left == 0;
      s_sda = !md_sda && !(slot >= 1 && slave_bit) && stuck_left == 0;
      if (stretch_left > 0) stretch_left--;
      if (stuck_left > 0) stuck_left--;
      prev_scl_d = md_scl;
      prev_sda_d = md_sda;
      send_item(MODE_TICK, s_sda, s_scl, KIND_STREAM, 7'd0, 8'd0, 7'd0, 8'd0, 1);
   endtask

   task automatic finish_transfer();
      int n;
      logic [1:0] nm;
      n = 0;
      while (!last_done && n < TickCap) begin
         if ($urandom_range(0, 99) < 2) begin
            case ($urandom_range(0, 2))
               0: nm = MODE_PUSH;
               1: nm = MODE_BEGIN;
               default: nm = MODE_UNUSED;
            endcase
            send_item(nm, $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 3),
                      $urandom_range(0, 127), $urandom_range(0, 255), $urandom_range(0, 64),
                      $urandom_range(0, 255), 1);
         end else begin
            line_tick();
         end
         n++;
      end
   endtask

   task automatic run_transfer(input logic [1:0] kind, input logic [6:0] addr,
                               input logic [7:0] regb, input int len, input int npush);
      for (int i = 0; i < npush; i++)
         send_item(MODE_PUSH, 0, 0, KIND_STREAM, 7'd0, 8'd0, 7'd0, $urandom_range(0, 255), 1);
      slot = -1;
      stretch_left = 0;
      stuck_left = ($urandom_range(0, 99) < 15) ? $urandom_range(1, 40) : 0;
      prev_scl_d = last_scl_d;
      prev_sda_d = last_sda_d;
      send_item(MODE_BEGIN, 0, 0, kind, addr, regb, len, 8'd0, 1);
      transfers++;
      finish_transfer();
   endtask

   task automatic random_transfer();
      logic [1:0] kind;
      int len, npush, r;
      kind = $urandom_range(0, 2);
      len = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 3) : $urandom_range(0, 12);
      if (kind == KIND_REG_RD && len == 0 && $urandom_range(0, 99) < 90) len = 1;
      npush = len + $urandom_range(0, 2);
      if ($urandom_range(0, 99) < 5 && len > 0) npush = len - 1;
      ack_pct = ($urandom_range(0, 99) < 80) ? 95 : 50;
      r = $urandom_range(0, 99);
      stretch_pct = (r < 50) ? 0 : (r < 85) ? 10 : 40;
      stretch_max = ($urandom_range(0, 99) < 5) ? 400 : $urandom_range(1, 20);
      zero_gaps = ($urandom_range(0, 99) < 15);
      run_transfer(kind, $urandom_range(0, 127), $urandom_range(0, 255), len, npush);
   endtask

   initial begin
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      req_tuser = MODE_TICK;
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
      csr_paddr = '0;
      csr_pwdata = '0;
      last_scl_d = 0;
      last_sda_d = 0;
      last_done = 0;
      prev_scl_d = 0;
      prev_sda_d = 0;
      slot = -1;
      ack_pct = 100;
      stretch_pct = 0;
      stretch_max = 1;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // idle-side items and every rejected request
      send_item(MODE_UNUSED, 1, 1, KIND_BAD, 7'h7F, 8'hFF, 7'h7F, 8'hFF, 1);
      send_item(MODE_TICK, 1, 1, KIND_STREAM, 7'd0, 8'd0, 7'd0, 8'd0, 1);
      send_item(MODE_PUSH, 0, 0, KIND_STREAM, 7'd0, 8'd0, 7'd0, 8'h00, 1);
      send_item(MODE_PUSH, 0, 0, KIND_STREAM, 7'd0, 8'd0, 7'd0, 8'hFF, 1);
      send_item(MODE_BEGIN, 0, 0, KIND_BAD, 7'd1, 8'd1, 7'd0, 8'd0, 1);
      send_item(MODE_BEGIN, 0, 0, KIND_REG_RD, 7'd1, 8'd1, 7'd0, 8'd0, 1);
      send_item(MODE_PUSH, 0, 0, KIND_STREAM, 7'd0, 8'd0, 7'd0, 8'h5A, 1);
      send_item(MODE_BEGIN, 0, 0, KIND_REG_WR, 7'd1, 8'd1, 7'h7F, 8'd0, 1);
      send_item(MODE_PUSH, 0, 0, KIND_STREAM, 7'd0, 8'd0, 7'd0, 8'hA5, 1);
      send_item(MODE_BEGIN, 0, 0, KIND_STREAM, 7'd1, 8'd1, 7'd2, 8'd0, 1);
      run_transfer(KIND_REG_RD, 7'h7F, 8'hFF, 1, 0);

      // short half period keeps the directed transfers brief
      apply_config(1, 300, 150000, 9);
      run_transfer(KIND_STREAM, 7'h00, 8'h00, 0, 0);
      run_transfer(KIND_REG_WR, 7'h55, 8'hAA, 2, 2);

      // back-pressure: result side stalls while noisy ticks keep coming
      send_item(MODE_BEGIN, 0, 0, KIND_REG_RD, 7'h2A, 8'h3C, 7'd2, 8'd0, 1);
      transfers++;
      hold_rsp = 1;
      for (int i = 0; i < 40; i++)
         send_item(MODE_TICK, $urandom_range(0, 1), $urandom_range(0, 1), KIND_STREAM,
                   7'd0, 8'd0, 7'd0, 8'd0, i == 39);
      drain();
      finish_transfer();

      // corner settings; full payload store, address NACKed
      ack_pct = 0;
      run_transfer(KIND_STREAM, $urandom_range(0, 127), 8'd0, 64, 66);
      ack_pct = 100;
      apply_config(0, 0, 262143, 15);
      stretch_pct = 30;
      stretch_max = 3;
      repeat (3) run_transfer($urandom_range(0, 2), $urandom_range(0, 127),
                              $urandom_range(0, 255), 1, 1);
      stretch_pct = 0;
      apply_config(4, 65535, 262143, 0);
      run_transfer(KIND_STREAM, $urandom_range(0, 127), 8'd0, 0, 0);
      apply_config(3, 5, 1, 1);
      run_transfer(KIND_REG_WR, 7'h12, 8'h34, 1, 1);
      apply_config(2, 65535, 200, 0);
      run_transfer(KIND_REG_RD, 7'h61, 8'h0F, 8, 0);

      while (req_cnt < 1550) begin
         apply_config($urandom_range(1, 2),
                      ($urandom_range(0, 99) < 50) ? 300 : $urandom_range(0, 30),
                      ($urandom_range(0, 99) < 80) ? 150000 : $urandom_range(50, 3000),
                      $urandom_range(0, 15));
         repeat (3) random_transfer();
      end

      zero_gaps = 0;
      drain();
      repeat (10) @(posedge clock);
      $display("run: %0d transactions, %0d transfers begun, %0d register settings",
               req_cnt, transfers, configs);
      $display("covered rejects, writes, reads, recovery, stretching and stalled results");
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
